// File: hw/rtl/plc_write_frame_builder_core_defines.svh
// Assertion macros used by the frame builder controller RTL.
`ifndef PLC_WRITE_FRAME_BUILDER_CORE_DEFINES_SVH
`define PLC_WRITE_FRAME_BUILDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PWFB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PWFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PWFB_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PWFB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/pwfb_pkg.sv
package pwfb_pkg;

    // Command codes.
    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SPEED_IDX  = 1'b0;
    localparam logic CFG_ENABLE_IDX = 1'b1;

    localparam logic [15:0] SPEED_ADDR_RESET  = 16'h10C8;
    localparam logic [15:0] ENABLE_ADDR_RESET = 16'h1258;

    // Frame characters.
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_A     = 8'h41;

    // Byte positions inside a frame.
    localparam logic [4:0] POS_ADDR_LAST = 5'd5;
    localparam logic [4:0] POS_CNT_HI    = 5'd6;
    localparam logic [4:0] POS_CNT_LO    = 5'd7;
    localparam logic [4:0] POS_DATA      = 5'd8;
    localparam logic [4:0] POS_RUN_DIR   = 5'd9;
    localparam logic [4:0] POS_ETX_SET   = 5'd24;
    localparam logic [4:0] POS_LAST_SET  = 5'd26;
    localparam logic [4:0] POS_ETX_RS    = 5'd12;
    localparam logic [4:0] POS_LAST_RS   = 5'd14;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       last;
        logic       chk_char;
        logic [4:0] pos;
    } pwfb_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic is_set;
        logic op_used;
    } pwfb_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {4'd0, nib};
        else
            c = CH_A + {4'd0, nib - 4'd10};
        return c;
    endfunction

endpackage

// File: hw/rtl/pwfb_ctrl.sv
`include "plc_write_frame_builder_core_defines.svh"

module pwfb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pwfb_pkg::pwfb_status_t status,
    output pwfb_pkg::pwfb_cmd_t    cmd
);
    import pwfb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] pos_reg, pos_next;
    logic [4:0] last_pos;
    logic [4:0] etx_pos;

    assign last_pos = status.is_set ? POS_LAST_SET : POS_LAST_RS;
    assign etx_pos  = status.is_set ? POS_ETX_SET : POS_ETX_RS;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.pos      = pos_reg;
        cmd.last     = (state_reg == ST_EMIT) && (pos_reg == last_pos);
        cmd.chk_char = (state_reg == ST_EMIT) && (pos_reg > etx_pos);
        state_next   = state_reg;
        pos_next     = pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.op_used)
                begin
                    // The start character needs no held data, so it is loaded on the same
                    // edge that takes the command when the output register is free.
                    cmd.capture = 1'b1;
                    cmd.load    = status.slot_free;
                    state_next  = ST_EMIT;
                    pos_next    = status.slot_free ? 5'd1 : 5'd0;
                end
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.load = 1'b1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = 5'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pos_next   = 5'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    `PWFB_ASSERT_IMPLY(a_load_needs_slot, cmd.load, status.slot_free, "byte loaded into a full output register")
    `PWFB_ASSERT_NEXT(a_last_ends_frame, cmd.load && cmd.last, state_reg == ST_IDLE, "frame did not end after its last byte")
    `PWFB_ASSERT_IMPLY(a_pos_in_frame, state_reg == ST_EMIT, pos_reg <= last_pos, "byte position ran past the frame end")
    `PWFB_ASSERT_NEXT(a_capture_starts, cmd.capture, state_reg == ST_EMIT && pos_reg <= 5'd1, "capture did not start a frame")

endmodule

// File: hw/rtl/pwfb_datapath.sv
module pwfb_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic [1:0]             op,
    input  logic [31:0]            frequency,
    input  logic [31:0]            position,
    input  logic                   direction,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [7:0]             frame_byte,
    output logic                   last_byte,
    input  pwfb_pkg::pwfb_cmd_t    cmd,
    output pwfb_pkg::pwfb_status_t status
);
    import pwfb_pkg::*;

    logic [15:0] speed_addr_reg;
    logic [15:0] enable_addr_reg;
    logic [1:0]  held_op_reg;
    logic [31:0] held_freq_reg;
    logic [31:0] held_pos_reg;
    logic        held_dir_reg;
    logic [7:0]  sum_reg, sum_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  frame_byte_reg;
    logic        last_byte_reg;

    logic        is_set;
    logic [15:0] addr;
    logic [4:0]  etx_pos;
    logic [3:0]  nib_idx;
    logic [31:0] word;
    logic [7:0]  word_byte;
    logic [3:0]  addr_nib;
    logic [7:0]  byte_next;

    assign is_set   = (held_op_reg == OP_SET);
    assign addr     = is_set ? speed_addr_reg : enable_addr_reg;
    assign etx_pos  = is_set ? POS_ETX_SET : POS_ETX_RS;
    assign nib_idx  = 4'(cmd.pos - POS_DATA);
    assign word     = nib_idx[3] ? held_pos_reg : held_freq_reg;
    assign word_byte = 8'(word >> {nib_idx[2:1], 3'b000});

    always_comb
    begin
        unique case (cmd.pos[1:0])
            2'd2:    addr_nib = addr[15:12];
            2'd3:    addr_nib = addr[11:8];
            2'd0:    addr_nib = addr[7:4];
            default: addr_nib = addr[3:0];
        endcase
    end

    always_comb
    begin
        priority if (cmd.pos == 5'd0)
            byte_next = CH_STX;
        else if (cmd.pos == 5'd1)
            byte_next = CH_ONE;
        else if (cmd.pos <= POS_ADDR_LAST)
            byte_next = hex_char(addr_nib);
        else if (cmd.pos == POS_CNT_HI)
            byte_next = CH_ZERO;
        else if (cmd.pos == POS_CNT_LO)
            byte_next = is_set ? CH_EIGHT : CH_TWO;
        else if (cmd.pos == etx_pos)
            byte_next = CH_ETX;
        else if (cmd.pos == etx_pos + 5'd1)
            byte_next = hex_char(sum_reg[7:4]);
        else if (cmd.pos == etx_pos + 5'd2)
            byte_next = hex_char(sum_reg[3:0]);
        else if (is_set)
            byte_next = hex_char(nib_idx[0] ? word_byte[3:0] : word_byte[7:4]);
        else if (cmd.pos == POS_RUN_DIR && held_op_reg == OP_RUN)
            byte_next = held_dir_reg ? CH_TWO : CH_ONE;
        else
            byte_next = CH_ZERO;
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.capture)
            sum_next = 8'd0;
        else if (cmd.load && cmd.pos != 5'd0 && !cmd.chk_char)
            sum_next = sum_reg + byte_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_addr_reg  <= SPEED_ADDR_RESET;
            enable_addr_reg <= ENABLE_ADDR_RESET;
            held_op_reg     <= OP_SET;
            sum_reg         <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SPEED_IDX:  speed_addr_reg  <= cfg_data;
                    CFG_ENABLE_IDX: enable_addr_reg <= cfg_data;
                    default:        speed_addr_reg  <= speed_addr_reg;
                endcase
            end
            if (cmd.capture)
                held_op_reg <= op;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            held_freq_reg <= frequency;
            held_pos_reg  <= position;
            held_dir_reg  <= direction;
        end
        if (cmd.load)
        begin
            frame_byte_reg <= byte_next;
            last_byte_reg  <= cmd.last;
        end
    end

    assign status.slot_free = !out_valid_reg || !out_stall;
    assign status.is_set    = is_set;
    assign status.op_used   = (op != OP_NONE);

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_byte_reg;

endmodule

// File: hw/rtl/plc_write_frame_builder_core.sv
// The start character of a frame is loaded into the output register on the edge of
// the command transfer when that register is free; the rest follow one per cycle while
// the output is not stalled. A set frame is 27 characters and a run or stop frame 15.
// A new command is taken only once the last character of the previous frame is loaded
// into the single output byte register, which the sequencer fills one byte at a time.
// Reset (rst_n, asynchronous, active low) empties the output, idles the sequencer and
// restores both register addresses to their defaults; no clearing pass is needed.
module plc_write_frame_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] frequency,
    input  logic [31:0] position,
    input  logic        direction,
    // Frame byte channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import pwfb_pkg::*;

    pwfb_cmd_t    cmd;
    pwfb_status_t status;

    // Register writes never wait, so the configuration channel is always ready. The user
    // must issue writes only while no frame is in flight; the block does not check it.
    assign cfg_ready = 1'b1;

    // The controller walks the byte position of the frame. It takes a command
    // only while idle; an unused command code is taken and dropped without
    // producing a frame. Because the final byte leaves the sequencer as soon
    // as it is loaded into the output register, the next command transfer can
    // happen while that byte still waits to be taken downstream.
    pwfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the captured command, the two address registers, the
    // running checksum and the output byte register. It turns the position it
    // is given into a frame character: header, address, byte count, the data (for a set,
    // the words as hex nibbles, low byte first, high nibble first; for run or stop, a
    // run direction or stop code), the end character and the two checksum characters.
    // The checksum covers every byte after the start character through the end character.
    pwfb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .frequency  (frequency),
        .position   (position),
        .direction  (direction),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// File: tb/sv/plc_write_frame_builder_core_tb.sv
module plc_write_frame_builder_core_tb;

    import pwfb_pkg::*;

    // A command transfer as it is placed on the command channel.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] frequency;
        logic [31:0] position;
        logic        direction;
    } plc_cmd_t;

    // One frame character that the block is expected to send.
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } frame_char_t;

    localparam int WATCHDOG_LIMIT = 4000;
    // A frame is at most 27 characters long; this settle time lets any command
    // without a frame leave the block.
    localparam int SETTLE_CYCLES  = 40;
    localparam int BUSY_PCT       = 36;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [31:0] frequency;
    logic [31:0] position;
    logic        direction;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Commands waiting to be driven, and frame characters waiting to arrive.
    plc_cmd_t    pending_cmds[$];
    frame_char_t expected_chars[$];

    // Our own copy of the two address registers.
    logic [15:0] speed_addr;
    logic [15:0] enable_addr;

    // Running state of the frame that is being predicted.
    logic [7:0]  frame_sum;
    int          frame_len;

    logic        cmd_pending;
    int          idle_pct;
    int          error_count;
    int          cmds_accepted;
    int          frames_predicted;
    int          chars_checked;
    int          cfg_writes;
    int          quiet_cycles;

    plc_write_frame_builder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .frequency  (frequency),
        .position   (position),
        .direction  (direction),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------

    // Upper-case ASCII hex digit for one nibble.
    function automatic logic [7:0] ascii_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        if (nib > 4'd9)
            return CH_A + (wide - 8'd10);
        return CH_ZERO + wide;
    endfunction

    // Queue one character. The start character is not part of the checksum;
    // everything after it is, up to and including the end character.
    function automatic void add_char(input logic [7:0] ch, input logic is_last);
        frame_char_t c;
        c.value   = ch;
        c.is_last = is_last;
        expected_chars.push_back(c);
        if (frame_len != 0)
            frame_sum = frame_sum + ch;
        frame_len++;
    endfunction

    // A byte travels as two hex characters, high nibble first.
    function automatic void add_hex_byte(input logic [7:0] v);
        add_char(ascii_digit(v[7:4]), 1'b0);
        add_char(ascii_digit(v[3:0]), 1'b0);
    endfunction

    // A 32-bit word travels least significant byte first.
    function automatic void add_hex_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_hex_byte(w[8 * i +: 8]);
    endfunction

    // Works out the whole frame that one accepted command causes.
    function automatic void predict_frame(input plc_cmd_t cmd);
        logic [15:0] addr;
        logic [7:0]  sum;
        if (cmd.op == OP_NONE)
            return;
        frame_len = 0;
        frame_sum = 8'd0;
        addr = (cmd.op == OP_SET) ? speed_addr : enable_addr;
        add_char(CH_STX, 1'b0);
        add_char(CH_ONE, 1'b0);
        add_hex_byte(addr[15:8]);
        add_hex_byte(addr[7:0]);
        if (cmd.op == OP_SET)
        begin
            // Byte count "08", then speed and position words.
            add_char(CH_ZERO, 1'b0);
            add_char(CH_EIGHT, 1'b0);
            add_hex_word(cmd.frequency);
            add_hex_word(cmd.position);
        end
        else
        begin
            // Byte count "02", then "0100"/"0200" for run or "0000" for stop.
            add_char(CH_ZERO, 1'b0);
            add_char(CH_TWO, 1'b0);
            add_char(CH_ZERO, 1'b0);
            if (cmd.op == OP_RUN)
                add_char(cmd.direction ? CH_TWO : CH_ONE, 1'b0);
            else
                add_char(CH_ZERO, 1'b0);
            add_char(CH_ZERO, 1'b0);
            add_char(CH_ZERO, 1'b0);
        end
        add_char(CH_ETX, 1'b0);
        sum = frame_sum;
        add_char(ascii_digit(sum[7:4]), 1'b0);
        add_char(ascii_digit(sum[3:0]), 1'b1);
        frames_predicted++;
    endfunction

    // ------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------

    // A command transfer happens at a rising edge with valid high and stall
    // low. The prediction is made from the values on the ports at that edge.
    always @(posedge clk)
    begin
        plc_cmd_t seen;
        if (rst_n && in_valid && !in_stall)
        begin
            seen.op        = op;
            seen.frequency = frequency;
            seen.position  = position;
            seen.direction = direction;
            predict_frame(seen);
            cmds_accepted++;
            cmd_pending = 1'b0;
        end
    end

    // New commands go out on the falling edge. A command that has not been
    // taken yet stays on the port unchanged; valid never looks at stall.
    // When the next command follows at once, valid simply stays high.
    always @(negedge clk)
    begin
        plc_cmd_t nxt;
        if (rst_n && !cmd_pending)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = pending_cmds.pop_front();
                op        <= nxt.op;
                frequency <= nxt.frequency;
                position  <= nxt.position;
                direction <= nxt.direction;
                in_valid  <= 1'b1;
                cmd_pending = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The frame receiver stalls at random, also on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    // ------------------------------------------------------------------
    // Frame monitor
    // ------------------------------------------------------------------

    // Each frame character transfer is checked against the oldest expected
    // character, field by field.
    always @(posedge clk)
    begin
        frame_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("frame byte %02h with none expected", frame_byte));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (frame_byte !== want.value)
                    report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                              frame_byte, want.value));
                if (last_byte !== want.is_last)
                    report_mismatch($sformatf("last_byte %b, expected %b (byte %02h)",
                                              last_byte, want.is_last, want.value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------

    // Counts cycles without any transfer on any channel. A correct block never
    // goes this long without moving something, even under heavy stalling.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Writes one address register and mirrors it in the local copy once the
    // write transfer has happened.
    task automatic write_address_reg(input logic idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_SPEED_IDX)
            speed_addr = data;
        else
            enable_addr = data;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_cmd(input logic [1:0] c_op, input logic [31:0] c_freq,
                             input logic [31:0] c_pos, input logic c_dir);
        plc_cmd_t c;
        c.op        = c_op;
        c.frequency = c_freq;
        c.position  = c_pos;
        c.direction = c_dir;
        pending_cmds.push_back(c);
    endtask

    // Word values lean toward the extremes and single-byte patterns now and
    // then, so that every hex digit and the carry in the checksum get exercised.
    function automatic logic [31:0] random_word();
        logic [31:0] pick;
        logic [31:0] w;
        pick = $urandom_range(9);
        w = $urandom;
        if (pick == 0)
            return 32'd0;
        if (pick == 1)
            return 32'hFFFF_FFFF;
        if (pick == 2)
            return w & 32'h0000_00FF;
        return w;
    endfunction

    // Queues a number of random commands. A small share uses the unused op
    // code, which the block ignores; those do not count toward the number.
    task automatic queue_random_cmds(input int count);
        logic [31:0] r;
        logic [1:0]  c_op;
        int          made;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 5)
            begin
                c_op = OP_NONE;
            end
            else
            begin
                r = $urandom_range(2);
                c_op = r[1:0];
                made++;
            end
            r = $urandom;
            queue_cmd(c_op, random_word(), random_word(), r[0]);
        end
    endtask

    // Waits until every command has been taken and every expected character
    // has come, then lets the block settle so that an ignored command in
    // flight cannot collide with a following register write.
    task automatic drain();
        while (pending_cmds.size() != 0 || cmd_pending || expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [31:0] r;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_SET;
        frequency   = 32'd0;
        position    = 32'd0;
        direction   = 1'b0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SPEED_IDX;
        cfg_data    = 16'd0;
        cmd_pending = 1'b0;
        idle_pct    = BUSY_PCT;
        error_count = 0;
        cmds_accepted    = 0;
        frames_predicted = 0;
        chars_checked    = 0;
        cfg_writes       = 0;
        quiet_cycles     = 0;
        frame_sum   = 8'd0;
        frame_len   = 0;
        speed_addr  = SPEED_ADDR_RESET;
        enable_addr = ENABLE_ADDR_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed commands with the reset addresses: word extremes, byte
        // order, every hex letter, both run directions, stop, the unused op
        // code, and set-only fields riding along on run and stop.
        queue_cmd(OP_SET,  32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_cmd(OP_SET,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_cmd(OP_SET,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
        queue_cmd(OP_SET,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
        queue_cmd(OP_SET,  32'h0000_0001, 32'h8000_0000, 1'b0);
        queue_cmd(OP_RUN,  32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_cmd(OP_RUN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_cmd(OP_STOP, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_cmd(OP_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_cmd(OP_NONE, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1);
        queue_cmd(OP_RUN,  32'h1357_9BDF, 32'h2468_ACE0, 1'b1);
        queue_cmd(OP_NONE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(OP_SET,  32'hFEDC_BA98, 32'h7654_3210, 1'b1);
        queue_random_cmds(70);
        drain();

        // Address extremes, one low and one high.
        write_address_reg(CFG_SPEED_IDX, 16'h0000);
        write_address_reg(CFG_ENABLE_IDX, 16'hFFFF);
        queue_random_cmds(80);
        drain();

        // The opposite extremes, with no idling on either side for the whole
        // stretch so that frames go back to back.
        write_address_reg(CFG_SPEED_IDX, 16'hFFFF);
        write_address_reg(CFG_ENABLE_IDX, 16'h0000);
        idle_pct = 0;
        queue_random_cmds(80);
        drain();
        idle_pct = BUSY_PCT;

        // Addresses made of hex letters and digits.
        write_address_reg(CFG_SPEED_IDX, 16'hABCD);
        write_address_reg(CFG_ENABLE_IDX, 16'h9EF1);
        queue_random_cmds(80);
        drain();

        // Two rounds of random addresses.
        for (int k = 0; k < 2; k++)
        begin
            r = $urandom;
            write_address_reg(CFG_SPEED_IDX, r[15:0]);
            write_address_reg(CFG_ENABLE_IDX, r[31:16]);
            queue_random_cmds(k == 0 ? 80 : 60);
            drain();
        end

        // Anything still expected now never arrived.
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d frame bytes never arrived", expected_chars.size()));

        $display("Covered %0d commands (%0d frames, %0d bytes checked), %0d register writes.",
                 cmds_accepted, frames_predicted, chars_checked, cfg_writes);
        $display("Mismatches found: %0d", error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
